[rtl/core/bba_pkg.sv]
// ----------------------------------------------------------------------------
// bba_pkg
// shared types and codes for the buddy block allocator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package bba_pkg;

  typedef logic [1:0] node_code_t;
  localparam node_code_t NODE_UNUSED = 2'd0;
  localparam node_code_t NODE_FREE   = 2'd1;
  localparam node_code_t NODE_SPLIT  = 2'd2;
  localparam node_code_t NODE_ALLOC  = 2'd3;

  typedef logic [1:0] status_t;
  localparam status_t STATUS_OK      = 2'd0;
  localparam status_t STATUS_NOSPACE = 2'd1;
  localparam status_t STATUS_BADOFS  = 2'd2;

  localparam logic ACTION_ALLOC = 1'b0;
  localparam logic ACTION_FREE  = 1'b1;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_CFG_WR,
    OP_CLR_STEP,
    OP_LOAD,
    OP_READ,
    OP_DOWN_LEFT,
    OP_DOWN_RIGHT,
    OP_NEXT,
    OP_UP,
    OP_WR_SPLIT,
    OP_WR_RFREE_DOWN,
    OP_WR_ALLOC,
    OP_WR_FREE,
    OP_RD_BUDDY,
    OP_WR_UNUSED,
    OP_WR_BUDDY_UNUSED
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   par_free_up;
  } dp_cmd_t;

  typedef struct packed {
    node_code_t rd_state;
    logic       alloc_req;
    logic       fits;
    logic       at_target;
    logic       below_order;
    logic       is_right;
    logic       at_root;
    logic       clr_last;
    logic       range_ok;
    logic       aligned;
    logic       ofs_bit;
  } dp_stat_t;

endpackage
`default_nettype wire

[rtl/core/bba_ram.sv]
// ----------------------------------------------------------------------------
// bba_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bba_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 127
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/core/bba_datapath.sv]
// ----------------------------------------------------------------------------
// bba_datapath
// node tree memory, walk registers, request latch and offset math
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bba_datapath #(
  parameter int MAX_ORDER       = 6,
  parameter int MIN_BLOCK_SHIFT = 20
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire bba_pkg::dp_cmd_t  cmd,
  output bba_pkg::dp_stat_t      stat,
  input  wire logic [2:0]        cfg_data,
  input  wire logic              in_action,
  input  wire logic [26:0]       in_size_bytes,
  input  wire logic [25:0]       in_block_offset,
  output logic [25:0]            out_granted_offset
);

  localparam int NODES = (2 << MAX_ORDER) - 1;
  localparam int IW    = $clog2(NODES);
  localparam int DW    = $clog2(MAX_ORDER + 2);
  localparam int PW    = MAX_ORDER;
  localparam int XW    = ((26 > MAX_ORDER + MIN_BLOCK_SHIFT) ? 26
                          : MAX_ORDER + MIN_BLOCK_SHIFT) + 1;

  logic [2:0]    pool_order_r;
  logic [IW-1:0] clr_cnt_r;
  logic [IW-1:0] idx_r;
  logic [DW-1:0] depth_r;
  logic [PW-1:0] pos_r;
  logic          action_r;
  logic [26:0]   size_r;
  logic [25:0]   offset_r;
  logic [25:0]   grant_r;

  logic [DW-1:0] order;
  logic [DW-1:0] k;
  logic [IW-1:0] parent;
  logic [IW-1:0] buddy;
  logic [IW-1:0] left;
  logic [XW-1:0] off_x;
  logic [XW-1:0] ofs_sh;
  logic [XW-1:0] grant_x;
  logic          we;
  logic [IW-1:0] waddr;
  bba_pkg::node_code_t wdata;
  logic [IW-1:0] raddr;
  bba_pkg::node_code_t rdata;

  always_comb begin
    if (int'(pool_order_r) > MAX_ORDER) begin
      order = DW'(MAX_ORDER);
    end else begin
      order = DW'(pool_order_r);
    end
  end

  // smallest k with size <= one minimum block shifted by k
  always_comb begin
    k = DW'(MAX_ORDER + 1);
    for (int i = MAX_ORDER; i >= 0; i--) begin
      if ({37'd0, size_r} <= (64'd1 << (i + MIN_BLOCK_SHIFT))) begin
        k = DW'(i);
      end
    end
  end

  assign left    = IW'({idx_r, 1'b1});
  assign parent  = IW'((idx_r - IW'(1)) >> 1);
  assign buddy   = idx_r[0] ? IW'(idx_r + IW'(1)) : IW'(idx_r - IW'(1));
  assign off_x   = XW'(offset_r);
  assign grant_x = XW'(pos_r) << (int'(order) - int'(depth_r) + MIN_BLOCK_SHIFT);
  // offset bit that picks the half below the current node
  assign ofs_sh  = off_x >> (int'(order) - int'(depth_r) - 1 + MIN_BLOCK_SHIFT);

  always_comb begin
    stat.rd_state    = rdata;
    stat.alloc_req   = (action_r == bba_pkg::ACTION_ALLOC);
    stat.fits        = (k <= order);
    stat.at_target   = (depth_r == DW'(order - k));
    stat.below_order = (depth_r < order);
    stat.is_right    = (idx_r != '0) && !idx_r[0];
    stat.at_root     = (idx_r == '0);
    stat.clr_last    = (clr_cnt_r == IW'(NODES - 1));
    stat.range_ok    = ((off_x >> (int'(order) + MIN_BLOCK_SHIFT)) == '0);
    stat.aligned     = ((off_x & ((XW'(1) << (int'(order) - int'(depth_r)
                        + MIN_BLOCK_SHIFT)) - XW'(1))) == '0);
    stat.ofs_bit     = ofs_sh[0];
  end

  always_comb begin
    we    = 1'b1;
    waddr = idx_r;
    wdata = bba_pkg::NODE_FREE;
    raddr = idx_r;
    if (cmd.par_free_up) begin
      waddr = parent;
    end else begin
      unique case (cmd.op)
        bba_pkg::OP_CLR_STEP: begin
          waddr = clr_cnt_r;
          wdata = (clr_cnt_r == '0) ? bba_pkg::NODE_FREE : bba_pkg::NODE_UNUSED;
        end
        bba_pkg::OP_WR_SPLIT:        wdata = bba_pkg::NODE_SPLIT;
        bba_pkg::OP_WR_RFREE_DOWN:   waddr = IW'(left + IW'(1));
        bba_pkg::OP_WR_ALLOC:        wdata = bba_pkg::NODE_ALLOC;
        bba_pkg::OP_WR_FREE:         wdata = bba_pkg::NODE_FREE;
        bba_pkg::OP_WR_UNUSED:       wdata = bba_pkg::NODE_UNUSED;
        bba_pkg::OP_WR_BUDDY_UNUSED: begin
          waddr = buddy;
          wdata = bba_pkg::NODE_UNUSED;
        end
        bba_pkg::OP_RD_BUDDY: begin
          we    = 1'b0;
          raddr = buddy;
        end
        default: we = 1'b0;
      endcase
    end
  end

  bba_ram #(
    .WIDTH (2),
    .DEPTH (NODES)
  ) u_tree (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr   (raddr),
    .rdata_r (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_order_r <= 3'd6;
      clr_cnt_r    <= '0;
    end else if (cmd.op == bba_pkg::OP_CFG_WR) begin
      pool_order_r <= cfg_data;
      clr_cnt_r    <= '0;
    end else if (cmd.op == bba_pkg::OP_CLR_STEP && !cmd.par_free_up) begin
      clr_cnt_r    <= IW'(clr_cnt_r + IW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.par_free_up) begin
      idx_r   <= parent;
      depth_r <= DW'(depth_r - DW'(1));
      pos_r   <= pos_r >> 1;
    end else begin
      unique case (cmd.op)
        bba_pkg::OP_LOAD: begin
          action_r <= in_action;
          size_r   <= in_size_bytes;
          offset_r <= in_block_offset;
          grant_r  <= '0;
          idx_r    <= '0;
          depth_r  <= '0;
          pos_r    <= '0;
        end
        bba_pkg::OP_DOWN_LEFT, bba_pkg::OP_WR_RFREE_DOWN: begin
          idx_r   <= left;
          depth_r <= DW'(depth_r + DW'(1));
          pos_r   <= PW'({pos_r, 1'b0});
        end
        bba_pkg::OP_DOWN_RIGHT: begin
          idx_r   <= IW'(left + IW'(1));
          depth_r <= DW'(depth_r + DW'(1));
          pos_r   <= PW'({pos_r, 1'b1});
        end
        bba_pkg::OP_NEXT: begin
          idx_r <= IW'(idx_r + IW'(1));
          pos_r <= PW'(pos_r + PW'(1));
        end
        bba_pkg::OP_UP: begin
          idx_r   <= parent;
          depth_r <= DW'(depth_r - DW'(1));
          pos_r   <= pos_r >> 1;
        end
        bba_pkg::OP_WR_ALLOC: grant_r <= grant_x[25:0];
        default: ;
      endcase
    end
  end

  assign out_granted_offset = grant_r;

endmodule
`default_nettype wire

[rtl/core/bba_ctrl.sv]
// ----------------------------------------------------------------------------
// bba_ctrl
// sequencer for tree clear, allocate search/split and free lookup/merge
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bba_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  output bba_pkg::dp_cmd_t       cmd,
  input  wire bba_pkg::dp_stat_t stat,
  output logic                   out_valid,
  output bba_pkg::status_t       out_status
);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_ACT, ST_A_RD, ST_A_EVAL, ST_A_SKIP, ST_A_CHAIN, ST_A_NEW,
    ST_F_RD, ST_F_EVAL, ST_F_MERGE, ST_F_BEVAL, ST_F_WB, ST_F_WP, ST_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic              out_valid_r, out_valid_nxt;
  bba_pkg::status_t  out_status_r, out_status_nxt;

  always_comb begin
    state_nxt       = state_r;
    out_valid_nxt   = 1'b0;
    out_status_nxt  = out_status_r;
    cmd.op          = bba_pkg::OP_NOP;
    cmd.par_free_up = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.op = bba_pkg::OP_CLR_STEP;
        if (stat.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cmd.op    = bba_pkg::OP_LOAD;
          state_nxt = ST_ACT;
        end else if (cfg_valid) begin
          cmd.op    = bba_pkg::OP_CFG_WR;
          state_nxt = ST_CLEAR;
        end
      end
      ST_ACT: begin
        if (stat.alloc_req ? !stat.fits : !stat.range_ok) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = stat.alloc_req ? bba_pkg::STATUS_NOSPACE
                                          : bba_pkg::STATUS_BADOFS;
          state_nxt      = ST_DONE;
        end else begin
          cmd.op    = bba_pkg::OP_READ;
          state_nxt = stat.alloc_req ? ST_A_EVAL : ST_F_EVAL;
        end
      end
      ST_A_RD: begin
        cmd.op    = bba_pkg::OP_READ;
        state_nxt = ST_A_EVAL;
      end
      ST_A_EVAL: begin
        if (stat.rd_state == bba_pkg::NODE_FREE) begin
          if (stat.at_target) begin
            cmd.op         = bba_pkg::OP_WR_ALLOC;
            out_valid_nxt  = 1'b1;
            out_status_nxt = bba_pkg::STATUS_OK;
            state_nxt      = ST_DONE;
          end else begin
            cmd.op    = bba_pkg::OP_WR_SPLIT;
            state_nxt = ST_A_CHAIN;
          end
        end else if (stat.rd_state == bba_pkg::NODE_SPLIT && !stat.at_target) begin
          cmd.op    = bba_pkg::OP_DOWN_LEFT;
          state_nxt = ST_A_RD;
        end else begin
          state_nxt = ST_A_SKIP;
        end
      end
      // climb while on a right child, then step to the right sibling
      ST_A_SKIP: begin
        if (stat.is_right) begin
          cmd.op = bba_pkg::OP_UP;
        end else if (stat.at_root) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = bba_pkg::STATUS_NOSPACE;
          state_nxt      = ST_DONE;
        end else begin
          cmd.op    = bba_pkg::OP_NEXT;
          state_nxt = ST_A_RD;
        end
      end
      // node just split: free the right child, descend left, which is free
      ST_A_CHAIN: begin
        cmd.op    = bba_pkg::OP_WR_RFREE_DOWN;
        state_nxt = ST_A_NEW;
      end
      // fresh left child of a split, known free without a read
      ST_A_NEW: begin
        if (stat.at_target) begin
          cmd.op         = bba_pkg::OP_WR_ALLOC;
          out_valid_nxt  = 1'b1;
          out_status_nxt = bba_pkg::STATUS_OK;
          state_nxt      = ST_DONE;
        end else begin
          cmd.op    = bba_pkg::OP_WR_SPLIT;
          state_nxt = ST_A_CHAIN;
        end
      end
      ST_F_RD: begin
        cmd.op    = bba_pkg::OP_READ;
        state_nxt = ST_F_EVAL;
      end
      ST_F_EVAL: begin
        if (stat.rd_state == bba_pkg::NODE_SPLIT && stat.below_order) begin
          cmd.op    = stat.ofs_bit ? bba_pkg::OP_DOWN_RIGHT : bba_pkg::OP_DOWN_LEFT;
          state_nxt = ST_F_RD;
        end else if (stat.rd_state == bba_pkg::NODE_ALLOC && stat.aligned) begin
          cmd.op    = bba_pkg::OP_WR_FREE;
          state_nxt = ST_F_MERGE;
        end else begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = bba_pkg::STATUS_BADOFS;
          state_nxt      = ST_DONE;
        end
      end
      ST_F_MERGE: begin
        if (stat.at_root) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = bba_pkg::STATUS_OK;
          state_nxt      = ST_DONE;
        end else begin
          cmd.op    = bba_pkg::OP_RD_BUDDY;
          state_nxt = ST_F_BEVAL;
        end
      end
      ST_F_BEVAL: begin
        if (stat.rd_state == bba_pkg::NODE_FREE) begin
          cmd.op    = bba_pkg::OP_WR_UNUSED;
          state_nxt = ST_F_WB;
        end else begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = bba_pkg::STATUS_OK;
          state_nxt      = ST_DONE;
        end
      end
      ST_F_WB: begin
        cmd.op    = bba_pkg::OP_WR_BUDDY_UNUSED;
        state_nxt = ST_F_WP;
      end
      ST_F_WP: begin
        cmd.par_free_up = 1'b1;
        state_nxt       = ST_F_MERGE;
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      out_valid_r  <= 1'b0;
      out_status_r <= bba_pkg::STATUS_OK;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign busy       = (state_r != ST_IDLE);
  // a request in the same cycle goes first
  assign cfg_ready  = (state_r == ST_IDLE) && !start;
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;

endmodule
`default_nettype wire

[rtl/core/buddy_block_allocator.sv]
// ----------------------------------------------------------------------------
// buddy_block_allocator
// binary buddy allocator over a pool of up to 2^MAX_ORDER minimum blocks
// ----------------------------------------------------------------------------
// channel   ports                                           transfer
// input     start, busy, in_action/size_bytes/block_offset  start & !busy
// result    out_valid, out_status, out_granted_offset       out_valid, one cycle
// config    cfg_valid, cfg_ready, cfg_data                  cfg_valid & cfg_ready
//
// one request at a time; the node tree lives in a ram with one read and one
// write port, and a node visit is a read followed by an evaluate
// allocate: searches nodes in order, then splits one level at a time down to
// the target; free: walks down one level at a time, then merges buddies
// upward level by level; after reset and after each config write a
// clearing pass over all 2^(MAX_ORDER+1)-1 tree nodes runs with busy high;
// the result side cannot stall
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module buddy_block_allocator #(
  parameter int MAX_ORDER       = 6,
  parameter int MIN_BLOCK_SHIFT = 20
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_action,
  input  wire logic [26:0] in_size_bytes,
  input  wire logic [25:0] in_block_offset,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [25:0]      out_granted_offset,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_data
);

  bba_pkg::dp_cmd_t  cmd;
  bba_pkg::dp_stat_t stat;

  bba_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_status (out_status)
  );

  bba_datapath #(
    .MAX_ORDER       (MAX_ORDER),
    .MIN_BLOCK_SHIFT (MIN_BLOCK_SHIFT)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .cfg_data           (cfg_data),
    .in_action          (in_action),
    .in_size_bytes      (in_size_bytes),
    .in_block_offset    (in_block_offset),
    .out_granted_offset (out_granted_offset)
  );

endmodule
`default_nettype wire

[bench/buddy_block_allocator_test.sv]
// ----------------------------------------------------------------------------
// buddy_block_allocator_test
// self-checking bench: a tree model of the allocator predicts each status and
// granted offset; random alloc/free traffic runs at several pool orders
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module buddy_block_allocator_test;

  localparam int MAXO      = 6;
  localparam int NODES     = (2 << MAXO) - 1;
  localparam int MB_SHIFT  = 20;
  localparam int CYC_LIMIT = 4000000;

  typedef struct packed {
    bba_pkg::status_t status;
    logic [25:0]      offset;
  } grant_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        in_action = 1'b0;
  logic [26:0] in_size_bytes = '0;
  logic [25:0] in_block_offset = '0;
  logic        cfg_valid = 1'b0;
  logic [2:0]  cfg_data = '0;
  wire         busy, out_valid, cfg_ready;
  wire [1:0]   out_status;
  wire [25:0]  out_granted_offset;

  int errors = 0;
  int cycles = 0;
  int idle_pct = 0;
  int n_alloc_ok = 0, n_nospace = 0, n_free_ok = 0, n_badofs = 0;
  logic [25:0] live[$];

  always #2 clk = ~clk;

  buddy_block_allocator dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_size_bytes(in_size_bytes),
    .in_block_offset(in_block_offset), .out_valid(out_valid),
    .out_status(out_status), .out_granted_offset(out_granted_offset),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  task automatic report(input string what);
    errors++;
    $display("error @%0t: %s", $realtime, what);
  endtask

  class grant_board;
    bba_pkg::node_code_t tree[NODES];
    logic [2:0]          order_reg;
    grant_t              pending[$];

    function void clear_tree(input logic [2:0] ord);
      order_reg = ord;
      foreach (tree[i]) tree[i] = bba_pkg::NODE_UNUSED;
      tree[0] = bba_pkg::NODE_FREE;
    endfunction

    function int eff_order();
      return (order_reg > MAXO) ? MAXO : int'(order_reg);
    endfunction

    function int find_block(input int idx, input int depth, input int target);
      int got;
      if (idx >= NODES || depth > target) return -1;
      if (tree[idx] == bba_pkg::NODE_FREE) begin
        if (depth == target) begin
          tree[idx] = bba_pkg::NODE_ALLOC;
          return idx;
        end
        if (2 * idx + 2 >= NODES) return -1;
        tree[idx] = bba_pkg::NODE_SPLIT;
        tree[2 * idx + 1] = bba_pkg::NODE_FREE;
        tree[2 * idx + 2] = bba_pkg::NODE_FREE;
        return find_block(2 * idx + 1, depth + 1, target);
      end
      if (tree[idx] == bba_pkg::NODE_SPLIT && depth < target) begin
        got = find_block(2 * idx + 1, depth + 1, target);
        if (got >= 0) return got;
        return find_block(2 * idx + 2, depth + 1, target);
      end
      return -1;
    endfunction

    function grant_t allocate(input logic [26:0] size);
      grant_t r;
      int ord, k, got, depth, pos;
      longint unsigned ofs;
      ord = eff_order();
      k = 0;
      r = '0;
      while (k <= MAXO && (64'd1 << (k + MB_SHIFT)) < size) k++;
      if (k > ord) begin
        r.status = bba_pkg::STATUS_NOSPACE;
        return r;
      end
      got = find_block(0, 0, ord - k);
      if (got < 0) begin
        r.status = bba_pkg::STATUS_NOSPACE;
        return r;
      end
      depth = 0;
      while (((got + 1) >> (depth + 1)) != 0) depth++;
      pos = got + 1 - (1 << depth);
      ofs = longint'(pos) << (ord - depth + MB_SHIFT);
      r.status = bba_pkg::STATUS_OK;
      r.offset = ofs[25:0];
      return r;
    endfunction

    function grant_t release_block(input logic [25:0] ofs);
      grant_t r;
      int ord, idx, depth, p;
      longint unsigned base, half;
      ord = eff_order();
      r = '0;
      r.status = bba_pkg::STATUS_BADOFS;
      if ((ofs >> MB_SHIFT) >= (1 << ord)) return r;
      idx = 0;
      depth = 0;
      base = 0;
      while (idx < NODES && tree[idx] == bba_pkg::NODE_SPLIT && depth < ord) begin
        half = 64'd1 << (ord - depth - 1 + MB_SHIFT);
        if (ofs >= base + half) begin
          base += half;
          idx = 2 * idx + 2;
        end else begin
          idx = 2 * idx + 1;
        end
        depth++;
      end
      if (idx >= NODES || tree[idx] != bba_pkg::NODE_ALLOC || ofs != base) return r;
      tree[idx] = bba_pkg::NODE_FREE;
      // merge buddies upward while both halves are free
      while (idx != 0) begin
        p = (idx - 1) / 2;
        if (tree[2 * p + 1] != bba_pkg::NODE_FREE ||
            tree[2 * p + 2] != bba_pkg::NODE_FREE) break;
        tree[2 * p + 1] = bba_pkg::NODE_UNUSED;
        tree[2 * p + 2] = bba_pkg::NODE_UNUSED;
        tree[p] = bba_pkg::NODE_FREE;
        idx = p;
      end
      r.status = bba_pkg::STATUS_OK;
      return r;
    endfunction

    function void note_request(input logic act, input logic [26:0] size,
                               input logic [25:0] ofs);
      grant_t g;
      if (act == bba_pkg::ACTION_ALLOC) begin
        g = allocate(size);
        if (g.status == bba_pkg::STATUS_OK) begin
          live.push_back(g.offset);
          n_alloc_ok++;
        end else begin
          n_nospace++;
        end
      end else begin
        g = release_block(ofs);
        if (g.status == bba_pkg::STATUS_OK) begin
          n_free_ok++;
          foreach (live[i]) if (live[i] == ofs) begin
            live.delete(i);
            break;
          end
        end else begin
          n_badofs++;
        end
      end
      pending.push_back(g);
    endfunction

    task check_grant(input logic [1:0] st, input logic [25:0] ofs);
      grant_t g;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result status %0d offset %h", st, ofs));
        return;
      end
      g = pending.pop_front();
      if (st != g.status)
        report($sformatf("status %0d, predicted %0d", st, g.status));
      if (ofs != g.offset)
        report($sformatf("offset %h, predicted %h", ofs, g.offset));
    endtask
  endclass

  grant_board board = new();

  always @(posedge clk) begin
    cycles++;
    if (rst_n && out_valid) board.check_grant(out_status, out_granted_offset);
    if (cycles >= CYC_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic issue(input logic act, input logic [26:0] size,
                       input logic [25:0] ofs);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) @(negedge clk);
    start <= 1'b1;
    in_action <= act;
    in_size_bytes <= size;
    in_block_offset <= ofs;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_request(act, size, ofs);
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_order(input logic [2:0] ord);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= ord;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.clear_tree(ord);
    live.delete();
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly realistic sizes, a few byte-exact edges
  function automatic logic [26:0] pick_size();
    int k;
    k = $urandom_range(6);
    case ($urandom_range(3))
      0: return 27'(1) << (k + MB_SHIFT);
      1: return (27'(1) << (k + MB_SHIFT)) + 27'(1);
      2: return 27'($urandom_range(1 << (k + MB_SHIFT)));
      default: return 27'($urandom);
    endcase
  endfunction

  task automatic random_burst(input int count);
    logic [25:0] ofs;
    repeat (count) begin
      if ($urandom_range(99) < 50 || live.size() == 0) begin
        issue(bba_pkg::ACTION_ALLOC, pick_size(), 26'($urandom));
      end else begin
        if ($urandom_range(9) < 8) ofs = live[$urandom_range(live.size() - 1)];
        else ofs = 26'($urandom);
        issue(bba_pkg::ACTION_FREE, 27'($urandom), ofs);
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    board.clear_tree(3'd6);

    // directed: zero size, whole pool, too large, bad frees, merge back
    issue(bba_pkg::ACTION_ALLOC, 27'd0, 26'h3ffffff);
    issue(bba_pkg::ACTION_ALLOC, 27'h4000000, 26'd0);
    issue(bba_pkg::ACTION_FREE, 27'h7ffffff, 26'd0);
    issue(bba_pkg::ACTION_ALLOC, 27'h7ffffff, 26'd0);
    issue(bba_pkg::ACTION_ALLOC, 27'h2000000, 26'd0);
    issue(bba_pkg::ACTION_FREE, 27'd0, 26'h3ffffff);
    issue(bba_pkg::ACTION_FREE, 27'd0, 26'h0100000);
    issue(bba_pkg::ACTION_FREE, 27'd0, 26'h0000001);
    issue(bba_pkg::ACTION_FREE, 27'd0, 26'd0);
    issue(bba_pkg::ACTION_FREE, 27'd0, 26'd0);
    issue(bba_pkg::ACTION_FREE, 27'd0, 26'h2000000);
    issue(bba_pkg::ACTION_ALLOC, 27'h4000000, 26'd0);
    set_order(3'd0);
    issue(bba_pkg::ACTION_ALLOC, 27'd1, 26'd0);
    issue(bba_pkg::ACTION_ALLOC, 27'd1, 26'd0);
    issue(bba_pkg::ACTION_FREE, 27'd0, 26'd0);
    issue(bba_pkg::ACTION_ALLOC, 27'h100001, 26'd0);
    set_order(3'd7);
    issue(bba_pkg::ACTION_ALLOC, 27'h4000000, 26'd0);
    issue(bba_pkg::ACTION_FREE, 27'd0, 26'd0);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 56;
        2: idle_pct = 0;
        default: idle_pct = 25;
      endcase
      set_order(3'(ph));
      random_burst(100);
      drain();
    end

    drain();
    $display("covered %0d grants, %0d no-space, %0d frees, %0d bad offsets",
             n_alloc_ok, n_nospace, n_free_ok, n_badofs);
    $display("pool orders 0 to 7 with idle and back-to-back phases");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire
